// ----- src/obrb_pkg.sv -----
// Package for the overwriting byte ring buffer.
// Holds the operation codes, the default depth, field widths and the
// controller/datapath command and status structs. No dependencies.
package obrb_pkg;

	// Default number of stored bytes
	localparam int unsigned DEPTH_DEFAULT = 64;

	// Fixed payload widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned FILL_W = 7;

	// Operation carried by each request transaction
	typedef enum logic [1:0] {
		KIND_PUT   = 2'd0,
		KIND_GET   = 2'd1,
		KIND_PEEK  = 2'd2,
		KIND_FLUSH = 2'd3
	} obrb_kind_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic put;       // store byte at head, advance pointers
		logic pop;       // advance tail, decrement fill count
		logic flush;     // zero pointers and fill count
		logic sweep;     // write zero at sweep address and advance it
		logic load_imm;  // load result register with zero byte and next count
		logic load_rd;   // load result register with registered memory data
	} obrb_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic empty;       // fill count is zero
		logic sweep_last;  // sweep address is at the final entry
	} obrb_stat_t;

endpackage

// ----- src/obrb_in_if.sv -----
// Request channel of the overwriting byte ring buffer.
// Carries valid/ready and the operation payload; depends on nothing.
interface obrb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic       clear_contents;

	modport source (output valid, output kind, output data_byte, output clear_contents,
		input ready);
	modport sink (input valid, input kind, input data_byte, input clear_contents,
		output ready);
endinterface

// ----- src/obrb_out_if.sv -----
// Response channel of the overwriting byte ring buffer.
// Carries valid/ready, the read byte and the fill count; depends on nothing.
interface obrb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic [6:0] fill_count;

	modport source (output valid, output read_byte, output fill_count, input ready);
	modport sink (input valid, input read_byte, input fill_count, output ready);
endinterface

// ----- src/obrb_dp.sv -----
// Datapath of the overwriting byte ring buffer: byte memory, head/tail
// pointers, fill count, clearing sweep address and result register.
// Depends on obrb_pkg for the command and status structs.
module obrb_dp #(
	parameter int unsigned DEPTH = obrb_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  obrb_pkg::obrb_cmd_t           cmd,
	output obrb_pkg::obrb_stat_t          stat,
	input  logic [obrb_pkg::BYTE_W-1:0]   data_byte,
	output logic [obrb_pkg::BYTE_W-1:0]   read_byte,
	output logic [obrb_pkg::FILL_W-1:0]   fill_count
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned OCC_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

	logic [obrb_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [obrb_pkg::BYTE_W-1:0] rd_data_q;
	logic [PTR_W-1:0]            wp_q;
	logic [PTR_W-1:0]            rp_q;
	logic [PTR_W-1:0]            sweep_q;
	logic [OCC_W-1:0]            occ_q;
	logic [OCC_W-1:0]            occ_next;
	logic [PTR_W-1:0]            wp_inc;
	logic [PTR_W-1:0]            rp_inc;
	logic [PTR_W-1:0]            sweep_inc;
	logic                        mem_we;
	logic [PTR_W-1:0]            mem_waddr;
	logic [obrb_pkg::BYTE_W-1:0] mem_wdata;
	logic [OCC_W+obrb_pkg::FILL_W-1:0] occ_ext;
	logic [obrb_pkg::BYTE_W-1:0] res_byte_q;
	logic [obrb_pkg::FILL_W-1:0] res_fill_q;

	// Pointer increments with wrap at the last entry
	assign wp_inc    = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign rp_inc    = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
	assign sweep_inc = (sweep_q == PTR_LAST) ? '0 : sweep_q + 1'b1;

	// Fill count after the current command
	always_comb begin
		occ_next = occ_q;
		if (cmd.flush) begin
			occ_next = '0;
		end else if (cmd.put && (occ_q != OCC_FULL)) begin
			occ_next = occ_q + 1'b1;
		end else if (cmd.pop) begin
			occ_next = occ_q - 1'b1;
		end
	end

	// Widen or truncate the count to the result field
	assign occ_ext = {{obrb_pkg::FILL_W{1'b0}}, occ_next};

	// Memory write port: sweep has the port to itself while it runs
	assign mem_we    = cmd.put || cmd.sweep;
	assign mem_waddr = cmd.sweep ? sweep_q : wp_q;
	assign mem_wdata = cmd.sweep ? '0 : data_byte;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rp_q];
	end

	// Pointers, fill count and sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			occ_q   <= '0;
			sweep_q <= '0;
		end else begin
			occ_q <= occ_next;
			if (cmd.flush) begin
				wp_q <= '0;
				rp_q <= '0;
			end else if (cmd.put) begin
				wp_q <= wp_inc;
				if (occ_q == OCC_FULL) begin
					rp_q <= rp_inc;
				end
			end else if (cmd.pop) begin
				rp_q <= rp_inc;
			end
			if (cmd.sweep) begin
				sweep_q <= sweep_inc;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_imm) begin
			res_byte_q <= '0;
			res_fill_q <= occ_ext[obrb_pkg::FILL_W-1:0];
		end else if (cmd.load_rd) begin
			res_byte_q <= rd_data_q;
			res_fill_q <= occ_ext[obrb_pkg::FILL_W-1:0];
		end
	end

	assign read_byte       = res_byte_q;
	assign fill_count      = res_fill_q;
	assign stat.empty      = (occ_q == '0);
	assign stat.sweep_last = (sweep_q == PTR_LAST);

endmodule

// ----- src/obrb_ctrl.sv -----
// Controller of the overwriting byte ring buffer: sequences each operation,
// runs the clearing sweep and owns the handshakes. Depends on obrb_pkg.
module obrb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           req_kind,
	input  logic                 req_clear,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output obrb_pkg::obrb_cmd_t  cmd,
	input  obrb_pkg::obrb_stat_t stat
);

	typedef enum logic [1:0] {
		ST_CLR_RST,
		ST_IDLE,
		ST_READ,
		ST_CLR_FLUSH
	} state_t;

	state_t              state_q;
	logic                rsp_valid_q;
	logic                accept;
	obrb_pkg::obrb_kind_t kind;

	assign kind      = obrb_pkg::obrb_kind_t'(req_kind);
	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	// Decode accepted operations, sweep and READ states into datapath commands
	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (kind)
				obrb_pkg::KIND_PUT: begin
					cmd.put      = 1'b1;
					cmd.load_imm = 1'b1;
				end
				obrb_pkg::KIND_GET: begin
					cmd.pop      = !stat.empty;
					cmd.load_imm = stat.empty;
				end
				obrb_pkg::KIND_PEEK: begin
					cmd.load_imm = 1'b0;
				end
				obrb_pkg::KIND_FLUSH: begin
					cmd.flush    = 1'b1;
					cmd.load_imm = !req_clear;
				end
				default: begin
					cmd.load_imm = 1'b0;
				end
			endcase
		end
		if ((state_q == ST_CLR_RST) || (state_q == ST_CLR_FLUSH)) begin
			cmd.sweep = 1'b1;
		end
		if ((state_q == ST_CLR_FLUSH) && stat.sweep_last) begin
			cmd.load_imm = 1'b1;
		end
		if (state_q == ST_READ) begin
			cmd.load_rd = 1'b1;
		end
	end

	// State and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_imm || cmd.load_rd) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR_RST: begin
					if (stat.sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (((kind == obrb_pkg::KIND_GET) && !stat.empty) ||
							(kind == obrb_pkg::KIND_PEEK)) begin
							state_q <= ST_READ;
						end else if ((kind == obrb_pkg::KIND_FLUSH) && req_clear) begin
							state_q <= ST_CLR_FLUSH;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_CLR_FLUSH: begin
					if (stat.sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/overwriting_byte_ring_buffer_core.sv -----
// Byte ring buffer that overwrites the oldest byte when full.
//
// Channels: req carries one operation per transaction (kind: put, get, peek,
// flush; data_byte for put; clear_contents for flush). rsp returns one
// transaction per request with read_byte and the fill count after it.
// Both use valid/ready; a transaction moves when both are high.
//
// Throughput: put, get on an empty buffer and flush without clear respond in
// the next cycle, one such request per cycle while rsp.ready is high. Get and
// peek pass through the READ state as the byte memory has a registered read
// port. Flush with clear zeroes each entry through the single write port.
//
// Reset: pointers and fill count clear at once; the memory is then swept to
// zero, one entry per cycle, while req.ready stays low.
//
// Stall: the result register holds a finished response while rsp.ready is
// low; a new request is taken in the cycle that the waiting response leaves.
// Depends on obrb_pkg, obrb_in_if, obrb_out_if, obrb_ctrl and obrb_dp.
module overwriting_byte_ring_buffer_core #(
	parameter int unsigned DEPTH = obrb_pkg::DEPTH_DEFAULT
) (
	input logic          clk,
	input logic          arst_n,
	obrb_in_if.sink      req,
	obrb_out_if.source   rsp
);

	obrb_pkg::obrb_cmd_t  cmd;
	obrb_pkg::obrb_stat_t stat;

	// Sequencing and handshakes
	obrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_kind  (req.kind),
		.req_clear (req.clear_contents),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Storage, pointers and result register
	obrb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.data_byte  (req.data_byte),
		.read_byte  (rsp.read_byte),
		.fill_count (rsp.fill_count)
	);

endmodule

// ----- tb/overwriting_byte_ring_buffer_core_test.sv -----
// Self-checking testbench for overwriting_byte_ring_buffer_core.
// A directed table and randomised put/get/peek/flush runs are checked against a ring model.
// Depends on obrb_pkg, obrb_in_if, obrb_out_if and the core itself.
module overwriting_byte_ring_buffer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH     = obrb_pkg::DEPTH_DEFAULT;
	localparam int unsigned PTR_W     = $clog2(DEPTH);
	localparam int          RAND_OPS  = 1200;
	localparam int          MAX_GAP   = 14;
	localparam int          HOLD_LEN  = 400;
	localparam int          HOLD_AT   = 300;
	localparam longint      LIMIT     = 500_000;

	typedef struct packed {
		logic [obrb_pkg::BYTE_W-1:0] rbyte;
		logic [obrb_pkg::FILL_W-1:0] fill;
	} rsp_fields_t;

	typedef struct packed {
		obrb_pkg::obrb_kind_t        kind;
		logic [obrb_pkg::BYTE_W-1:0] data;
		logic                        clr;
		logic                        known;   // expected response written into the row
		logic [obrb_pkg::BYTE_W-1:0] rbyte;
		logic [obrb_pkg::FILL_W-1:0] fill;
	} stim_row_t;

	localparam int N_ROWS = 23;

	// Directed opening: reset state, empty cases, stale peeks, both flush kinds
	stim_row_t directed_rows [N_ROWS] = '{
		'{obrb_pkg::KIND_PEEK,  8'h00, 1'b0, 1'b1, 8'h00, 7'd0},
		'{obrb_pkg::KIND_GET,   8'h00, 1'b0, 1'b1, 8'h00, 7'd0},
		'{obrb_pkg::KIND_PUT,   8'hFF, 1'b0, 1'b1, 8'h00, 7'd1},
		'{obrb_pkg::KIND_PUT,   8'h00, 1'b0, 1'b1, 8'h00, 7'd2},
		'{obrb_pkg::KIND_PUT,   8'hA5, 1'b1, 1'b0, 8'h00, 7'd0},
		'{obrb_pkg::KIND_PEEK,  8'h3C, 1'b0, 1'b0, 8'h00, 7'd0},
		'{obrb_pkg::KIND_GET,   8'h00, 1'b1, 1'b0, 8'h00, 7'd0},
		'{obrb_pkg::KIND_GET,   8'h00, 1'b0, 1'b0, 8'h00, 7'd0},
		'{obrb_pkg::KIND_GET,   8'h00, 1'b0, 1'b0, 8'h00, 7'd0},
		'{obrb_pkg::KIND_GET,   8'h00, 1'b0, 1'b1, 8'h00, 7'd0},
		'{obrb_pkg::KIND_PEEK,  8'h00, 1'b0, 1'b0, 8'h00, 7'd0},
		'{obrb_pkg::KIND_PUT,   8'h5A, 1'b0, 1'b0, 8'h00, 7'd0},
		'{obrb_pkg::KIND_GET,   8'h00, 1'b0, 1'b0, 8'h00, 7'd0},
		'{obrb_pkg::KIND_FLUSH, 8'h00, 1'b0, 1'b1, 8'h00, 7'd0},
		'{obrb_pkg::KIND_PEEK,  8'h00, 1'b0, 1'b0, 8'h00, 7'd0},
		'{obrb_pkg::KIND_GET,   8'h00, 1'b0, 1'b1, 8'h00, 7'd0},
		'{obrb_pkg::KIND_FLUSH, 8'hFF, 1'b1, 1'b1, 8'h00, 7'd0},
		'{obrb_pkg::KIND_PEEK,  8'h00, 1'b0, 1'b1, 8'h00, 7'd0},
		'{obrb_pkg::KIND_PUT,   8'h80, 1'b0, 1'b1, 8'h00, 7'd1},
		'{obrb_pkg::KIND_PUT,   8'h01, 1'b0, 1'b1, 8'h00, 7'd2},
		'{obrb_pkg::KIND_PEEK,  8'h00, 1'b0, 1'b0, 8'h00, 7'd0},
		'{obrb_pkg::KIND_FLUSH, 8'h00, 1'b0, 1'b1, 8'h00, 7'd0},
		'{obrb_pkg::KIND_PUT,   8'h7F, 1'b0, 1'b0, 8'h00, 7'd0}
	};

	logic clk;
	logic arst_n;

	obrb_in_if  req_ch ();
	obrb_out_if rsp_ch ();

	overwriting_byte_ring_buffer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Ring model state
	logic [obrb_pkg::BYTE_W-1:0] ring_mem [DEPTH];
	logic [PTR_W-1:0]            head_ptr;
	logic [PTR_W-1:0]            tail_ptr;
	int unsigned                 fill_level;

	rsp_fields_t due_responses [$];
	int          err_count;
	int          rsp_seen;
	bit          send_burst;
	bit          recv_burst;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Apply one operation to the ring model and return the response it owes
	function automatic rsp_fields_t ring_step(input obrb_pkg::obrb_kind_t k,
		input logic [7:0] d, input logic c);
		rsp_fields_t r;
		r = '0;
		case (k)
			obrb_pkg::KIND_PUT: begin
				ring_mem[head_ptr] = d;
				head_ptr = ptr_next(head_ptr);
				if (fill_level < DEPTH)
					fill_level++;
				else
					tail_ptr = ptr_next(tail_ptr);
			end
			obrb_pkg::KIND_GET: begin
				if (fill_level > 0) begin
					r.rbyte = ring_mem[tail_ptr];
					tail_ptr = ptr_next(tail_ptr);
					fill_level--;
				end
			end
			obrb_pkg::KIND_PEEK: begin
				r.rbyte = ring_mem[tail_ptr];
			end
			default: begin
				fill_level = 0;
				head_ptr = '0;
				tail_ptr = '0;
				if (c)
					foreach (ring_mem[i]) ring_mem[i] = '0;
			end
		endcase
		r.fill = obrb_pkg::FILL_W'(fill_level);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] MISMATCH response %0d %s: got %0d, want %0d",
			$time, rsp_seen, what, got, want);
		err_count++;
	endtask

	// Offer one request after a random gap; log what it owes once accepted
	task automatic offer_op(input obrb_pkg::obrb_kind_t k, input logic [7:0] d,
		input logic c, input logic known, input rsp_fields_t known_rsp);
		int gap;
		rsp_fields_t want;
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.kind           <= k;
		req_ch.data_byte      <= d;
		req_ch.clear_contents <= c;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		want = ring_step(k, d, c);
		if (known)
			want = known_rsp;
		due_responses.push_back(want);
	endtask

	task automatic offer_rand(input obrb_pkg::obrb_kind_t k);
		logic c;
		c = (k == obrb_pkg::KIND_FLUSH) ? ($urandom_range(0, 3) == 0) :
			1'($urandom_range(0, 1));
		offer_op(k, 8'($urandom), c, 1'b0, '0);
	endtask

	function automatic obrb_pkg::obrb_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return obrb_pkg::KIND_PUT;
		else if (r < 75)
			return obrb_pkg::KIND_GET;
		else if (r < 95)
			return obrb_pkg::KIND_PEEK;
		return obrb_pkg::KIND_FLUSH;
	endfunction

	// Stimulus: reset, directed table, then randomised runs
	initial begin
		int sent;
		int run;
		int seg;
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.kind           = obrb_pkg::KIND_PUT;
		req_ch.data_byte      = '0;
		req_ch.clear_contents = 1'b0;
		send_burst            = 1'b0;
		err_count             = 0;
		fill_level            = 0;
		head_ptr              = '0;
		tail_ptr              = '0;
		foreach (ring_mem[i]) ring_mem[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer_op(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].clr,
				directed_rows[i].known, '{directed_rows[i].rbyte, directed_rows[i].fill});
		sent = N_ROWS;

		while (sent < N_ROWS + RAND_OPS) begin
			seg = $urandom_range(0, 9);
			send_burst = ($urandom_range(0, 3) == 0);
			case (seg)
				// overfill so puts overwrite the oldest byte
				0, 1: begin
					run = DEPTH + $urandom_range(0, 10);
					for (int i = 0; i < run; i++) offer_rand(obrb_pkg::KIND_PUT);
				end
				// drain past empty
				2, 3: begin
					run = DEPTH + $urandom_range(0, 4);
					for (int i = 0; i < run; i++) offer_rand($urandom_range(0, 4) == 0 ?
						obrb_pkg::KIND_PEEK : obrb_pkg::KIND_GET);
				end
				// partial fill and drain to move the pointers round the wrap
				9: begin
					run = $urandom_range(1, DEPTH - 1);
					for (int i = 0; i < run; i++) offer_rand(obrb_pkg::KIND_PUT);
					for (int i = 0; i < run; i++) offer_rand(obrb_pkg::KIND_GET);
					run = 2 * run;
				end
				default: begin
					run = 30;
					for (int i = 0; i < run; i++) offer_rand(pick_kind());
				end
			endcase
			sent += run;
		end
		req_ch.valid <= 1'b0;

		// Drain outstanding responses, then allow for a trailing clearing flush
		while (due_responses.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (err_count == 0)
			$display("overwriting_byte_ring_buffer_core verification clean");
		else
			$display("overwriting_byte_ring_buffer_core verification failed");
		$finish;
	end

	// Response side: random stalls, one long hold-off, field checks
	initial begin
		int stall;
		rsp_fields_t want;
		rsp_ch.ready = 1'b0;
		rsp_seen     = 0;
		recv_burst   = 1'b0;
		forever begin
			if (rsp_seen % 64 == 0)
				recv_burst = ($urandom_range(0, 2) == 0);
			stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (rsp_seen == HOLD_AT)
				stall = HOLD_LEN;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				for (int c = 0; c < stall; c++) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			rsp_seen++;
			if (due_responses.size() == 0) begin
				report_mismatch("unexpected transaction, fill", rsp_ch.fill_count, -1);
			end else begin
				want = due_responses.pop_front();
				if (rsp_ch.read_byte !== want.rbyte)
					report_mismatch("read_byte", rsp_ch.read_byte, want.rbyte);
				if (rsp_ch.fill_count !== want.fill)
					report_mismatch("fill_count", rsp_ch.fill_count, want.fill);
			end
		end
	end

	// Watchdog
	initial begin
		longint cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("overwriting_byte_ring_buffer_core verification failed");
		$finish;
	end

endmodule
